// ----- sv/two_line_lcd_log_terminal_macros.svh -----
// Assertion helpers shared by the lcdlog modules.
`ifndef TWO_LINE_LCD_LOG_TERMINAL_MACROS_SVH
`define TWO_LINE_LCD_LOG_TERMINAL_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LCDLOG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define LCDLOG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/lcdlog_pkg.sv -----
package lcdlog_pkg;

   localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
   localparam logic [7:0] LINE_TWO_BASE = 8'h40;
   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] BLANK         = 8'h20;

   // output byte source
   typedef logic [2:0] sel_type;
   localparam sel_type SEL_CLEAR  = 3'd0;
   localparam sel_type SEL_HEAD1  = 3'd1;
   localparam sel_type SEL_SHADOW = 3'd2;
   localparam sel_type SEL_HEAD2  = 3'd3;
   localparam sel_type SEL_BLANK  = 3'd4;
   localparam sel_type SEL_ADDR   = 3'd5;
   localparam sel_type SEL_DATA   = 3'd6;

   typedef struct packed {
      logic    capture;  // request accepted this cycle
      logic    emit;     // load output register
      logic    last;
      sel_type sel;
      logic    rd_en;    // shadow prefetch
      logic    cnt_clr;
      logic    cnt_inc;
      logic    clear;    // cursor to 0, shadow blank
      logic    scroll;   // cursor to line two start, shadow blank
      logic    advance;  // character written at cursor
   } cmd_type;

   typedef struct packed {
      logic out_busy;
      logic action;
      logic full;
      logic cnt_end;
   } sts_type;

endpackage

// ----- sv/lcdlog_req_if.sv -----
interface lcdlog_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] character;

   modport source (output valid, output action, output character, input ready);
   modport sink   (input valid, input action, input character, output ready);
endinterface

// ----- sv/lcdlog_rsp_if.sv -----
interface lcdlog_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_data;
   logic [7:0] bus_byte;
   logic       last;

   modport source (output valid, output is_data, output bus_byte, output last, input ready);
   modport sink   (input valid, input is_data, input bus_byte, input last, output ready);
endinterface

// ----- sv/lcdlog_ctrl.sv -----
`include "two_line_lcd_log_terminal_macros.svh"

module lcdlog_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lcdlog_pkg::sts_type sts,
   output lcdlog_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FIRST  = 3'd1;
   localparam logic [2:0] ST_SHADOW = 3'd2;
   localparam logic [2:0] ST_HEAD2  = 3'd3;
   localparam logic [2:0] ST_BLANK  = 3'd4;
   localparam logic [2:0] ST_ADDR   = 3'd5;
   localparam logic [2:0] ST_DATA   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       emit_ok;
   logic       final_tx;

   always_comb begin
      emit_ok  = !sts.out_busy;
      final_tx = 1'b0;
      state_in = state_ff;
      cmd      = '0;
      cmd.sel  = lcdlog_pkg::SEL_DATA;

      case (state_ff)
         ST_IDLE: begin
         end
         ST_FIRST: begin
            if (sts.action) begin
               cmd.sel   = lcdlog_pkg::SEL_CLEAR;
               cmd.clear = 1'b1;
               final_tx  = 1'b1;
            end else if (sts.full) begin
               cmd.sel     = lcdlog_pkg::SEL_HEAD1;
               cmd.rd_en   = 1'b1;
               cmd.cnt_clr = 1'b1;
               if (emit_ok) state_in = ST_SHADOW;
            end else begin
               cmd.sel = lcdlog_pkg::SEL_ADDR;
               if (emit_ok) state_in = ST_DATA;
            end
         end
         ST_SHADOW: begin
            cmd.sel   = lcdlog_pkg::SEL_SHADOW;
            cmd.rd_en = 1'b1;
            if (sts.cnt_end) begin
               cmd.cnt_clr = 1'b1;
               if (emit_ok) state_in = ST_HEAD2;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_HEAD2: begin
            cmd.sel     = lcdlog_pkg::SEL_HEAD2;
            cmd.cnt_clr = 1'b1;
            cmd.scroll  = 1'b1;
            if (emit_ok) state_in = ST_BLANK;
         end
         ST_BLANK: begin
            cmd.sel = lcdlog_pkg::SEL_BLANK;
            if (sts.cnt_end) begin
               cmd.cnt_clr = 1'b1;
               if (emit_ok) state_in = ST_ADDR;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_ADDR: begin
            cmd.sel = lcdlog_pkg::SEL_ADDR;
            if (emit_ok) state_in = ST_DATA;
         end
         ST_DATA: begin
            cmd.sel     = lcdlog_pkg::SEL_DATA;
            cmd.advance = 1'b1;
            final_tx    = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      cmd.emit = (state_ff != ST_IDLE) && (state_ff inside {ST_FIRST, ST_SHADOW, ST_HEAD2,
                 ST_BLANK, ST_ADDR, ST_DATA}) && emit_ok;
      cmd.last = final_tx;

      // next request may enter as the last transaction of this one goes out
      req_ready   = !reset && ((state_ff == ST_IDLE) || (final_tx && emit_ok));
      cmd.capture = req_ready && req_valid;

      if (cmd.capture) state_in = ST_FIRST;
      else if (final_tx && emit_ok) state_in = ST_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   `LCDLOG_ASSERT_NEXT(a_capture_starts, cmd.capture, state_ff == ST_FIRST, "request not started")
   `LCDLOG_ASSERT_NOW(a_ready_when_free, req_ready, state_ff == ST_IDLE || cmd.emit, "ready while busy")
   `LCDLOG_ASSERT_NOW(a_no_emit_busy, sts.out_busy, !cmd.emit, "emit into stalled output")

endmodule

// ----- sv/lcdlog_dp.sv -----
`include "two_line_lcd_log_terminal_macros.svh"

module lcdlog_dp #(
   parameter int LINE_LEN = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_action,
   input  logic [7:0]          req_character,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_is_data,
   output logic [7:0]          rsp_bus_byte,
   output logic                rsp_last,
   input  lcdlog_pkg::cmd_type cmd,
   output lcdlog_pkg::sts_type sts
);

   localparam int CW = $clog2(2 * LINE_LEN + 1);
   localparam int IW = $clog2(LINE_LEN);

   logic          action_ff;
   logic [7:0]    char_ff;
   logic [CW-1:0] cursor_ff, cursor_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_col;
   logic          wr_en, rd_en;
   logic          on_line_one;
   logic [LINE_LEN-1:0] vld_ff, vld_in;
   logic [7:0]    shadow_mem [LINE_LEN];
   logic [7:0]    rd_data_ff;
   logic          rd_vld_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          is_data_ff;
   logic [7:0]    byte_ff;
   logic          last_ff;
   logic          is_data_nx;
   logic [7:0]    byte_nx;
   logic [7:0]    addr_off;

   assign on_line_one = cursor_ff < CW'(LINE_LEN);
   assign wr_col      = IW'(cursor_ff - CW'(LINE_LEN));
   assign wr_en       = cmd.emit && cmd.advance && !on_line_one;
   assign rd_en       = cmd.emit && cmd.rd_en;
   assign rd_addr     = cmd.cnt_clr ? '0 : cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         char_ff   <= req_character;
      end
   end

   always_comb begin
      cursor_in = cursor_ff;
      cnt_in    = cnt_ff;
      vld_in    = vld_ff;
      if (cmd.emit) begin
         if (cmd.clear) cursor_in = '0;
         else if (cmd.scroll) cursor_in = CW'(LINE_LEN);
         else if (cmd.advance) cursor_in = cursor_ff + 1'b1;
         if (cmd.cnt_clr) cnt_in = '0;
         else if (cmd.cnt_inc) cnt_in = cnt_ff + 1'b1;
         if (cmd.clear || cmd.scroll) vld_in = '0;
      end
      if (wr_en) vld_in[wr_col] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         cnt_ff    <= '0;
         vld_ff    <= '0;
      end else begin
         cursor_ff <= cursor_in;
         cnt_ff    <= cnt_in;
         vld_ff    <= vld_in;
      end
   end

   // line-two shadow; entries without a valid bit read as blank
   always_ff @(posedge clock) begin
      if (wr_en) shadow_mem[wr_col] <= char_ff;
      if (rd_en) begin
         rd_data_ff <= shadow_mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   always_comb begin
      if (on_line_one) addr_off = 8'(cursor_ff);
      else addr_off = 8'(cursor_ff - CW'(LINE_LEN)) + lcdlog_pkg::LINE_TWO_BASE;
   end

   always_comb begin
      is_data_nx = 1'b0;
      byte_nx    = lcdlog_pkg::CMD_CLEAR;
      case (cmd.sel)
         lcdlog_pkg::SEL_CLEAR: begin
            byte_nx = lcdlog_pkg::CMD_CLEAR;
         end
         lcdlog_pkg::SEL_HEAD1: begin
            byte_nx = lcdlog_pkg::CMD_SET_ADDR;
         end
         lcdlog_pkg::SEL_SHADOW: begin
            is_data_nx = 1'b1;
            byte_nx    = rd_vld_ff ? rd_data_ff : lcdlog_pkg::BLANK;
         end
         lcdlog_pkg::SEL_HEAD2: begin
            byte_nx = lcdlog_pkg::CMD_SET_ADDR + lcdlog_pkg::LINE_TWO_BASE;
         end
         lcdlog_pkg::SEL_BLANK: begin
            is_data_nx = 1'b1;
            byte_nx    = lcdlog_pkg::BLANK;
         end
         lcdlog_pkg::SEL_ADDR: begin
            byte_nx = lcdlog_pkg::CMD_SET_ADDR + addr_off;
         end
         lcdlog_pkg::SEL_DATA: begin
            is_data_nx = 1'b1;
            byte_nx    = char_ff;
         end
         default: begin
            byte_nx = lcdlog_pkg::CMD_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         is_data_ff <= is_data_nx;
         byte_ff    <= byte_nx;
         last_ff    <= cmd.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_data  = is_data_ff;
   assign rsp_bus_byte = byte_ff;
   assign rsp_last     = last_ff;

   assign sts.out_busy = rsp_valid_ff && !rsp_ready;
   assign sts.action   = action_ff;
   assign sts.full     = cursor_ff >= CW'(2 * LINE_LEN);
   assign sts.cnt_end  = cnt_ff == IW'(LINE_LEN - 1);

   `LCDLOG_ASSERT_NOW(a_cursor_range, 1'b1, cursor_ff <= CW'(2 * LINE_LEN), "cursor out of range")
   `LCDLOG_ASSERT_NEXT(a_clear_home, cmd.emit && cmd.clear, cursor_ff == '0 && vld_ff == '0, "clear failed")
   `LCDLOG_ASSERT_NEXT(a_scroll_home, cmd.emit && cmd.scroll, cursor_ff == CW'(LINE_LEN), "scroll cursor")
   `LCDLOG_ASSERT_NOW(a_write_line_two, wr_en, cursor_ff < CW'(2 * LINE_LEN), "write past line two")

endmodule

// ----- sv/two_line_lcd_log_terminal.sv -----
// Ordinary character: address command then data, one per cycle unless the output stalls;
// back-to-back characters overlap, the next request entering as the data goes out.
// Scroll (display full): 2*LINE_LEN+4 transactions, one per cycle unless the output stalls;
// line one comes from the shadow read port. Clear: one transaction. Output is registered.
// Reset: cursor to 0, shadow valid bits cleared at once so line two reads as blanks;
// no clearing pass, requests taken right after reset.
module two_line_lcd_log_terminal #(
   parameter int LINE_LEN = 16
) (
   input  logic                clock,
   input  logic                reset,
   lcdlog_req_if.sink          req_chan,
   lcdlog_rsp_if.source        rsp_chan
);

   lcdlog_pkg::cmd_type cmd;
   lcdlog_pkg::sts_type sts;
   logic                req_ready;

   lcdlog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lcdlog_dp #(
      .LINE_LEN (LINE_LEN)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_action    (req_chan.action),
      .req_character (req_chan.character),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_is_data   (rsp_chan.is_data),
      .rsp_bus_byte  (rsp_chan.bus_byte),
      .rsp_last      (rsp_chan.last),
      .cmd           (cmd),
      .sts           (sts)
   );

   assign req_chan.ready = req_ready;

endmodule
